// File: src/assert_macros.svh
// Assertion macros shared by the checker modules.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, disabled while rst is high.
`define KVT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("key_value_table: assertion failed");

// Concurrent assertion sampled on clk that also covers reset cycles.
`define KVT_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("key_value_table: reset assertion failed");

`endif

// File: src/kvt_pkg.sv
// Shared types, constants and helpers for the key/value table.
// No dependencies; imported by every module of the block.
package kvt_pkg;

  localparam int unsigned KVT_ENTRIES     = 16;
  localparam int unsigned KVT_KEY_BYTES   = 8;
  localparam int unsigned KVT_VALUE_BYTES = 8;
  localparam int unsigned WORD_W          = 64;
  localparam int unsigned CFG_W           = 5;
  localparam logic [CFG_W-1:0] CFG_RESET  = 5'd16;

  // Operation codes carried in the kind field
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // Pass of a token through the chain
  localparam logic PHASE_SEARCH = 1'b0;
  localparam logic PHASE_CLAIM  = 1'b1;

  // Request token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic              phase;
    logic              done;
    logic              free_seen;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] vout;
  } kvt_tok_t;

  // Keep at most nbytes bytes and stop at the first zero byte
  function automatic logic [WORD_W-1:0] text_word(input logic [WORD_W-1:0] w,
                                                  input int unsigned nbytes);
    logic [WORD_W-1:0] r;
    logic              stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i >= nbytes || w[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*i +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

endpackage

// File: src/key_value_table.sv
// Top level of the key/value table: controller plus a chain of entry cells.
// Depends on kvt_pkg, kvt_ctrl and kvt_cell.
//
// One word is taken at a time. The request token walks the chain of ENTRIES
// cells, one cell per cycle, so a get or a put that hits an existing key
// delivers its result after one walk of the chain, and the next word is
// accepted in that same cycle. A put that misses and lands in a free entry
// walks the chain a second time to claim it. A result that waits on
// out_stall goes to a two-deep buffer, so one more word can be taken while it
// waits. The whole store clears in the reset cycle; no clearing pass.
module key_value_table import kvt_pkg::*; #(
  parameter int unsigned ENTRIES     = KVT_ENTRIES,
  parameter int unsigned KEY_BYTES   = KVT_KEY_BYTES,
  parameter int unsigned VALUE_BYTES = KVT_VALUE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [WORD_W-1:0] key,
  input  logic [WORD_W-1:0] value_in,
  input  logic              cfg_wen,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [WORD_W-1:0] value_out
);

  kvt_tok_t         chain [ENTRIES+1];
  logic [CFG_W-1:0] limit;

  kvt_ctrl #(
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .key       (key),
    .value_in  (value_in),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .value_out (value_out),
    .limit     (limit),
    .launch    (chain[0]),
    .tail      (chain[ENTRIES])
  );

  // Chain the entry cells, lowest entry first
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .limit   (limit),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

endmodule

// File: src/kvt_cell.sv
// One table entry: holds a key and a value and acts on the passing token.
// Depends on kvt_pkg for the token type and the operation codes.
module kvt_cell import kvt_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] limit,
  input  kvt_tok_t         tok_in,
  output kvt_tok_t         tok_out
);

  logic [WORD_W-1:0] key_reg;
  logic [WORD_W-1:0] value_reg;
  kvt_tok_t          tok_next;
  logic              active;
  logic              hit;
  logic              free;
  logic              wr_key;
  logic              wr_val;

  // Compare the token against this entry
  always_comb begin
    active   = 32'(limit) > IDX;
    hit      = tok_in.valid && active && !tok_in.done && (key_reg == tok_in.key);
    free     = tok_in.valid && active && (key_reg[7:0] == 8'h00);
    tok_next = tok_in;
    wr_key   = 1'b0;
    wr_val   = 1'b0;
    if (tok_in.phase == PHASE_SEARCH) begin
      if (hit) begin
        tok_next.done = 1'b1;
        if (tok_in.kind == KIND_GET) begin
          tok_next.vout = value_reg;
        end else begin
          wr_val = 1'b1;
        end
      end
      if (free) tok_next.free_seen = 1'b1;
    end else if (free && !tok_in.done) begin
      tok_next.done = 1'b1;
      wr_key        = 1'b1;
      wr_val        = 1'b1;
    end
  end

  // Update the entry and hand the token on
  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg   <= '0;
      value_reg <= '0;
      tok_out   <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr_key) key_reg <= tok_in.key;
      if (wr_val) value_reg <= tok_in.value;
    end
  end

endmodule

// File: src/kvt_ctrl.sv
// Front end of the table: input handshake, count register, pass control
// and the two-deep result buffer. Depends on kvt_pkg.
module kvt_ctrl import kvt_pkg::*; #(
  parameter int unsigned KEY_BYTES   = KVT_KEY_BYTES,
  parameter int unsigned VALUE_BYTES = KVT_VALUE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [WORD_W-1:0] key,
  input  logic [WORD_W-1:0] value_in,
  input  logic              cfg_wen,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [WORD_W-1:0] value_out,
  output logic [CFG_W-1:0]  limit,
  output kvt_tok_t          launch,
  input  kvt_tok_t          tail
);

  logic              busy;
  logic              skid_valid;
  logic              skid_ok;
  logic [WORD_W-1:0] skid_vout;
  logic              accept;
  logic              relaunch;
  logic              fin;
  logic              drain;
  logic              out_free;

  assign in_stall = busy || skid_valid;
  assign accept   = in_valid && !in_stall;
  assign drain    = out_valid && !out_stall;
  assign out_free = !out_valid || drain;

  // A put that missed but saw a free entry goes round again to claim it
  assign relaunch = tail.valid && (tail.phase == PHASE_SEARCH) &&
                    (tail.kind == KIND_PUT) && !tail.done && tail.free_seen;
  assign fin      = tail.valid && !relaunch;

  // Build the token entering the first cell
  always_comb begin
    launch = '0;
    if (relaunch) begin
      launch       = tail;
      launch.phase = PHASE_CLAIM;
    end else if (accept) begin
      launch.valid = 1'b1;
      launch.kind  = kind;
      launch.phase = PHASE_SEARCH;
      launch.key   = text_word(key, KEY_BYTES);
      launch.value = text_word(value_in, VALUE_BYTES);
    end
  end

  // Hold the count, track the item in flight, buffer results
  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= CFG_RESET;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_wen) limit <= cfg_wdata;

      if (accept) begin
        busy <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
      end

      if (fin && out_free) begin
        out_valid <= 1'b1;
        ok        <= tail.done;
        value_out <= tail.vout;
      end else if (drain && skid_valid) begin
        ok        <= skid_ok;
        value_out <= skid_vout;
      end else if (drain) begin
        out_valid <= 1'b0;
      end

      if (fin && !out_free) begin
        skid_valid <= 1'b1;
        skid_ok    <= tail.done;
        skid_vout  <= tail.vout;
      end else if (drain && skid_valid) begin
        skid_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/kvt_checker.sv
// Port-level checks for the key/value table, bound to the top level.
// Depends on kvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvt_checker import kvt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              ok,
  input logic [WORD_W-1:0] value_out
);

  // Hold a stalled result word
  `KVT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `KVT_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(ok) && $stable(value_out))
  // Block the input while an accepted word is in the chain
  `KVT_ASSERT(a_one_in_flight, in_valid && !in_stall |=> in_stall)
  // Leave reset empty and ready
  `KVT_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall)

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);
